>>> rtl/core/multi_stack_shared_buffer_core_assert.svh
// Assertion macros shared by the multi-stack buffer RTL.
`ifndef MULTI_STACK_SHARED_BUFFER_CORE_ASSERT_SVH
`define MULTI_STACK_SHARED_BUFFER_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define MSSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define MSSB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mssb_pkg.sv
// Shared types and constants for the multi-stack buffer.
package mssb_pkg;

  // Fixed field widths of the word ports
  localparam int STACK_ID_W = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  // Operation codes
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;        // capture word, read top and free-head link
    logic fetch;         // read link and data of the top entry
    logic commit_look;   // finish push or failed op
    logic commit_fetch;  // finish successful pop
  } mssb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_fetch;    // current op is a pop that will succeed
  } mssb_sts_t;

endpackage

>>> rtl/core/mssb_ctrl.sv
// Sequencing state machine and output handshake for the multi-stack buffer.
`include "multi_stack_shared_buffer_core_assert.svh"

module mssb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mssb_pkg::mssb_sts_t sts_i,
  output mssb_pkg::mssb_cmd_t cmd_o
);
  import mssb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       commit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit     = cmd_o.commit_look || cmd_o.commit_fetch;

  // Next state and commands
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.need_fetch) begin
          cmd_o.fetch = 1'b1;
          state_d     = S_FETCH;
        end else if (out_free) begin
          cmd_o.commit_look = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_FETCH: begin
        if (out_free) begin
          cmd_o.commit_fetch = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MSSB_ASSERT_IMPLIES(a_commit_slot_free, commit, out_free, "commit while output word blocked")
  `MSSB_ASSERT_NEXT(a_commit_sets_valid, commit, out_valid_q, "committed word not presented")
  `MSSB_ASSERT_NEXT(a_accept_to_look, cmd_o.accept, state_q == S_LOOK, "accept did not start lookup")

endmodule

>>> rtl/core/mssb_datapath.sv
// Stack memories, free list and result registers for the multi-stack buffer.
`include "multi_stack_shared_buffer_core_assert.svh"

module mssb_datapath #(
  parameter int NUM_STACKS   = 8,
  parameter int BUFFER_DEPTH = 256,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mssb_pkg::mssb_cmd_t               cmd_i,
  output mssb_pkg::mssb_sts_t               sts_o,
  input  logic                              kind_i,
  input  logic [mssb_pkg::STACK_ID_W-1:0]   stack_id_i,
  input  logic [mssb_pkg::VALUE_W-1:0]      push_value_i,
  output logic [mssb_pkg::STATUS_W-1:0]     status_o,
  output logic [mssb_pkg::VALUE_W-1:0]      pop_value_o
);
  import mssb_pkg::*;

  localparam int ADDR_W     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LINK_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int TOP_IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SID_WIDE_W = TOP_IDX_W + STACK_ID_W;
  localparam int VAL_WIDE_W = DATA_WIDTH + VALUE_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BUFFER_DEPTH);

  // Storage: entries past the fill mark were never written; their next free entry is taken as i+1
  logic [DATA_WIDTH-1:0] data_mem [BUFFER_DEPTH];
  logic [LINK_W-1:0]     link_mem [BUFFER_DEPTH];
  logic [LINK_W-1:0]     top_mem  [NUM_STACKS];
  logic [NUM_STACKS-1:0] top_vld_q;

  logic                  kind_q;
  logic [STACK_ID_W-1:0] sid_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [LINK_W-1:0]     free_head_q, hwm_q;
  logic [LINK_W-1:0]     link_rd_q, top_rd_q;
  logic                  top_vld_rd_q;
  logic [DATA_WIDTH-1:0] data_rd_q;
  status_e               status_q;
  logic [VALUE_W-1:0]    pop_value_q;

  logic [SID_WIDE_W-1:0] sid_in_wide, sid_q_wide;
  logic [TOP_IDX_W-1:0]  idx_in, idx_q;
  logic [VAL_WIDE_W-1:0] push_wide, pop_wide;
  logic [ADDR_W-1:0]     fh_addr, top_addr;
  logic [LINK_W-1:0]     fh_plus1, next_free, top_link;
  logic                  sid_ok, free_null, top_null, fresh;
  logic                  push_hit, pop_hit, push_wr, pop_wr;

  // Index and width conversions
  assign sid_in_wide = {{TOP_IDX_W{1'b0}}, stack_id_i};
  assign sid_q_wide  = {{TOP_IDX_W{1'b0}}, sid_q};
  assign idx_in      = sid_in_wide[TOP_IDX_W-1:0];
  assign idx_q       = sid_q_wide[TOP_IDX_W-1:0];
  assign push_wide   = {{DATA_WIDTH{1'b0}}, push_value_i};
  assign pop_wide    = {{VALUE_W{1'b0}}, data_rd_q};
  assign fh_addr     = free_head_q[ADDR_W-1:0];
  assign top_addr    = top_rd_q[ADDR_W-1:0];

  // Op decode after the lookup read
  assign sid_ok    = sid_q_wide < SID_WIDE_W'(NUM_STACKS);
  assign free_null = free_head_q >= NULL_LINK;
  assign top_null  = !top_vld_rd_q || (top_rd_q >= NULL_LINK);
  assign top_link  = top_null ? NULL_LINK : top_rd_q;
  assign fresh     = free_head_q >= hwm_q;
  assign fh_plus1  = free_head_q + LINK_W'(1);
  assign next_free = fresh ? fh_plus1 : link_rd_q;
  assign push_hit  = (kind_q == KIND_PUSH) && sid_ok && !free_null;
  assign pop_hit   = (kind_q == KIND_POP) && sid_ok && !top_null;
  assign push_wr   = cmd_i.commit_look && push_hit;
  assign pop_wr    = cmd_i.commit_fetch;

  assign sts_o.need_fetch = pop_hit;

  // Input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      sid_q  <= stack_id_i;
      val_q  <= push_wide[DATA_WIDTH-1:0];
    end
  end

  // Memory reads and writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      link_rd_q <= link_mem[fh_addr];
      top_rd_q  <= top_mem[idx_in];
    end else if (cmd_i.fetch) begin
      link_rd_q <= link_mem[top_addr];
      data_rd_q <= data_mem[top_addr];
    end
    if (push_wr) begin
      data_mem[fh_addr] <= val_q;
      link_mem[fh_addr] <= top_link;
      top_mem[idx_q]    <= free_head_q;
    end
    if (pop_wr) begin
      link_mem[top_addr] <= free_head_q;
      top_mem[idx_q]     <= link_rd_q;
    end
  end

  // Free head, fill mark and top valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      hwm_q        <= '0;
      top_vld_q    <= '0;
      top_vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        top_vld_rd_q <= top_vld_q[idx_in];
      end
      if (push_wr) begin
        free_head_q      <= next_free;
        top_vld_q[idx_q] <= 1'b1;
        if (fresh) begin
          hwm_q <= fh_plus1;
        end
      end else if (pop_wr) begin
        free_head_q <= top_rd_q;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_look) begin
      pop_value_q <= '0;
      if (push_hit) begin
        status_q <= ST_OK;
      end else if (kind_q == KIND_PUSH) begin
        status_q <= ST_FULL;
      end else begin
        status_q <= ST_EMPTY;
      end
    end else if (cmd_i.commit_fetch) begin
      status_q    <= ST_OK;
      pop_value_q <= pop_wide[VALUE_W-1:0];
    end
  end

  assign status_o    = status_q;
  assign pop_value_o = pop_value_q;

  `MSSB_ASSERT_ALWAYS(a_fill_mark_range, hwm_q <= NULL_LINK, "fill mark beyond buffer")
  `MSSB_ASSERT_IMPLIES(a_pop_entry_written, cmd_i.commit_fetch, top_rd_q < hwm_q, "pop of unwritten entry")
  `MSSB_ASSERT_IMPLIES(a_fetch_only_on_hit, cmd_i.fetch, pop_hit, "entry fetch without a pop hit")

endmodule

>>> rtl/core/multi_stack_shared_buffer_core.sv
// Top level of the multi-stack shared buffer: controller plus datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: kind_i (0 push,
//   1 pop), stack_id_i and push_value_i. Output channel (out_valid_o /
//   out_stall_i) returns one word per input: status_o (0 ok, 1 full on push,
//   2 empty on pop) and pop_value_o (popped data, zero otherwise).
//   A push or failed op has its result registered as the lookup state ends,
//   a successful pop as the fetch state after it ends: every op does one
//   registered read of the stack-top and link memories, and a pop then needs
//   a second read of the top entry's link and data before the write-back.
//   The next word is accepted in the cycle after the result is registered,
//   so a new op is taken only once the previous one has committed.
//   After reset all stacks are empty and the whole buffer is free; no clearing
//   pass runs, untouched entries are tracked by a fill mark instead.
//   If the receiver stalls, the result holds in the output register and one
//   more word may be accepted and looked up; it then waits until the output
//   register frees before committing.
module multi_stack_shared_buffer_core #(
  parameter int NUM_STACKS   = 8,
  parameter int BUFFER_DEPTH = 256,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [mssb_pkg::STACK_ID_W-1:0] stack_id_i,
  input  logic [mssb_pkg::VALUE_W-1:0]    push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mssb_pkg::STATUS_W-1:0]   status_o,
  output logic [mssb_pkg::VALUE_W-1:0]    pop_value_o
);
  import mssb_pkg::*;

  mssb_cmd_t cmd;
  mssb_sts_t sts;

  // Sequencer
  mssb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memories and free list
  mssb_datapath #(
    .NUM_STACKS   (NUM_STACKS),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .stack_id_i   (stack_id_i),
    .push_value_i (push_value_i),
    .status_o     (status_o),
    .pop_value_o  (pop_value_o)
  );

endmodule
